@@ src/esbr_pkg.sv @@
// Shared types and constants for the exact-size buffer recycler.
// Used by esbr_scan and by the exact_size_buffer_recycler_unit top level.
package esbr_pkg;

  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned OUTCOME_W = 3;

  // Result codes.
  localparam logic [OUTCOME_W-1:0] OUT_REUSED        = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_NEW_TRACKED   = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_NEW_UNTRACKED = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_ALLOC_FAILED  = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_FREED         = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUT_RELEASE       = 3'd5;

  // Request codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // One table entry as it is stored in the entry memory.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic                free;
  } esbr_entry_t;

  // One finished result handed from the sequencer to the output stage.
  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic [OUTCOME_W-1:0] outcome;
  } esbr_result_t;

endpackage

@@ src/exact_size_buffer_recycler_unit.sv @@
// Top level of the exact-size buffer recycler: entry memory, request
// sequencer and response register. Depends on esbr_pkg, esbr_ram, esbr_scan.
//
//  Channel   Handshake             Payload
//  --------  --------------------  ---------------------------------------------
//  request   req_valid / req_stall opcode, size_bytes, buffer_handle,
//                                  fresh_handle, backing_ok
//  response  rsp_valid / rsp_stall result_handle, outcome
//
// The time from a request's transfer until its response is valid depends on
// the scan, which reads one entry per cycle from the single read port of the
// entry memory, over the N tracked entries (N at most TABLE_ENTRIES); a hit
// ends the scan early, and an empty table skips the scan.
// Reset clears the entry count and all control state. The entry memory itself
// is not cleared, since only entries below the count are ever read.
// The response register lets a new request transfer while the previous result
// is still stalled; that request's own result then waits for the register.
module exact_size_buffer_recycler_unit #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        opcode,
  input  logic [31:0] size_bytes,
  input  logic [31:0] buffer_handle,
  input  logic [31:0] fresh_handle,
  input  logic        backing_ok,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] result_handle,
  output logic [2:0]  outcome
);

  import esbr_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic         rd_en;
  logic [IDX_W-1:0] rd_addr;
  esbr_entry_t  rd_data;
  logic         wr_en;
  logic [IDX_W-1:0] wr_addr;
  esbr_entry_t  wr_data;

  logic         res_valid;
  esbr_result_t res;
  logic         res_taken;

  // Handle, size and free mark of every entry share one memory word.
  esbr_ram #(
    .WIDTH ($bits(esbr_entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  esbr_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .opcode        (opcode),
    .size_bytes    (size_bytes),
    .buffer_handle (buffer_handle),
    .fresh_handle  (fresh_handle),
    .backing_ok    (backing_ok),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .res_valid     (res_valid),
    .res           (res),
    .res_taken     (res_taken)
  );

  // The response register loads a finished result whenever it is empty or its current result
  // is transferring in this same cycle.
  assign res_taken = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_taken) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      result_handle <= res.handle;
      outcome       <= res.outcome;
    end
  end

endmodule

@@ src/esbr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module esbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]       wr_data,
  input  logic                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/esbr_scan.sv @@
// Request sequencer: latches one request, scans the entry memory one entry per
// cycle, updates a hit entry or appends on a tracked miss. Depends on esbr_pkg.
module esbr_scan #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  // Request channel.
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         opcode,
  input  logic [31:0]                  size_bytes,
  input  logic [31:0]                  buffer_handle,
  input  logic [31:0]                  fresh_handle,
  input  logic                         backing_ok,
  // Entry memory ports.
  output logic                         rd_en,
  output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr,
  input  esbr_pkg::esbr_entry_t        rd_data,
  output logic                         wr_en,
  output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] wr_addr,
  output esbr_pkg::esbr_entry_t        wr_data,
  // Finished result toward the output stage.
  output logic                         res_valid,
  output esbr_pkg::esbr_result_t       res,
  input  logic                         res_taken
);

  import esbr_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MISS = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state, state_next;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    ptr;
  logic [CNT_W-1:0]    left;
  logic                pend;
  logic [IDX_W-1:0]    pend_idx;

  logic                op;
  logic [SIZE_W-1:0]   size;
  logic [HANDLE_W-1:0] handle;
  logic [HANDLE_W-1:0] fresh;
  logic                ok;

  esbr_result_t        result;

  logic accept;
  logic issue;
  logic match;
  logic hit;
  logic room;

  assign accept    = (state == S_IDLE) && req_valid;
  assign req_stall = (state != S_IDLE);
  assign issue     = (state == S_SCAN) && (left != '0);
  assign room      = (count < CNT_W'(TABLE_ENTRIES));

  assign match = (op == OP_ALLOC) ? ((rd_data.size == size) && rd_data.free)
                                  : (rd_data.handle == handle);
  assign hit   = (state == S_SCAN) && pend && match;

  assign rd_en   = issue;
  assign rd_addr = ptr;

  // Memory writes: set a hit's free mark by opcode, or append on a tracked miss.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_idx;
    wr_data = rd_data;
    if (hit) begin
      wr_en        = 1'b1;
      wr_data.free = (op == OP_FREE);
    end else if ((state == S_MISS) && (op == OP_ALLOC) && ok && room) begin
      wr_en          = 1'b1;
      wr_addr        = IDX_W'(count);
      wr_data.handle = fresh;
      wr_data.size   = size;
      wr_data.free   = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (count == '0) ? S_MISS : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_DONE;
        end else if (left == '0) begin
          state_next = S_MISS;
        end
      end
      S_MISS: state_next = S_DONE;
      S_DONE: begin
        if (res_taken) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_MISS) && (op == OP_ALLOC) && ok && room) begin
        count <= count + 1'b1;
      end
      if (accept) begin
        pend <= 1'b0;
      end else if (state == S_SCAN) begin
        pend <= issue;
      end
    end
  end

  // Request payload and scan pointers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= opcode;
      size   <= size_bytes;
      handle <= buffer_handle;
      fresh  <= fresh_handle;
      ok     <= backing_ok;
      left   <= count;
      // Allocate scans upward from entry 0, free scans down from the last entry.
      ptr    <= (opcode == OP_FREE) ? IDX_W'(count - 1'b1) : '0;
    end else if (issue) begin
      left     <= left - 1'b1;
      pend_idx <= ptr;
      ptr      <= (op == OP_FREE) ? ptr - 1'b1 : ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      if (op == OP_ALLOC) begin
        result.handle  <= rd_data.handle;
        result.outcome <= OUT_REUSED;
      end else begin
        result.handle  <= '0;
        result.outcome <= OUT_FREED;
      end
    end else if (state == S_MISS) begin
      if (op == OP_FREE) begin
        result.handle  <= handle;
        result.outcome <= OUT_RELEASE;
      end else if (!ok) begin
        result.handle  <= '0;
        result.outcome <= OUT_ALLOC_FAILED;
      end else if (room) begin
        result.handle  <= fresh;
        result.outcome <= OUT_NEW_TRACKED;
      end else begin
        result.handle  <= fresh;
        result.outcome <= OUT_NEW_UNTRACKED;
      end
    end
  end

  assign res_valid = (state == S_DONE);
  assign res       = result;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for exact_size_buffer_recycler_unit.
// It holds its own model of the recycler table, sends directed and then random
// alloc/free requests, and compares every response. Depends on esbr_pkg.
module tb_top;
  import esbr_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 128;
  localparam int unsigned RANDOM_ITEMS = 1200;
  // The last requests run with no idling on either side.
  localparam int unsigned CALM_ITEMS   = 150;
  // The longest scan reads every tracked entry, one entry per cycle.
  localparam int unsigned DRAIN_CYCLES = TABLE_DEPTH + 40;

  // One request as the sender presents it.
  typedef struct packed {
    logic        op;
    logic [31:0] size;
    logic [31:0] handle;
    logic [31:0] fresh;
    logic        ok;
  } recycle_req_t;

  // Tracks the recycler table as the block should see it. Requests are noted in
  // transfer order; each one yields the result the block owes for it.
  class recycler_tracker;
    logic [31:0]  slot_handle[TABLE_DEPTH];
    logic [31:0]  slot_size[TABLE_DEPTH];
    bit           slot_free[TABLE_DEPTH];
    int           slot_count;
    esbr_result_t pending_results[$];
    int unsigned  mismatches;

    function new();
      slot_count = 0;
      mismatches = 0;
    endfunction

    // Applies one request to the table and returns the result it causes.
    function esbr_result_t recycle_outcome(recycle_req_t r);
      esbr_result_t res;
      int idx;
      if (r.op == OP_ALLOC) begin
        // Reuse goes to the lowest-index free entry of exactly that size.
        for (idx = 0; idx < slot_count; idx++) begin
          if (slot_size[idx] == r.size && slot_free[idx]) begin
            slot_free[idx] = 1'b0;
            res.handle  = slot_handle[idx];
            res.outcome = OUT_REUSED;
            return res;
          end
        end
        if (!r.ok) begin
          res.handle  = '0;
          res.outcome = OUT_ALLOC_FAILED;
        end else if (slot_count < TABLE_DEPTH) begin
          slot_handle[slot_count] = r.fresh;
          slot_size[slot_count]   = r.size;
          slot_free[slot_count]   = 1'b0;
          slot_count++;
          res.handle  = r.fresh;
          res.outcome = OUT_NEW_TRACKED;
        end else begin
          res.handle  = r.fresh;
          res.outcome = OUT_NEW_UNTRACKED;
        end
      end else begin
        // A free marks the highest-index entry holding the handle.
        for (idx = slot_count - 1; idx >= 0; idx--) begin
          if (slot_handle[idx] == r.handle) begin
            slot_free[idx] = 1'b1;
            res.handle  = '0;
            res.outcome = OUT_FREED;
            return res;
          end
        end
        res.handle  = r.handle;
        res.outcome = OUT_RELEASE;
      end
      return res;
    endfunction

    function void take_request(recycle_req_t r);
      pending_results.push_back(recycle_outcome(r));
    endfunction

    function void match_result(logic [31:0] handle, logic [2:0] code);
      esbr_result_t want;
      if (pending_results.size() == 0) begin
        $error("response with nothing pending: result_handle %h, outcome %0d",
               handle, code);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (code !== want.outcome) begin
        $error("outcome: expected %0d, actual %0d", want.outcome, code);
        mismatches++;
      end
      if (handle !== want.handle) begin
        $error("result_handle: expected %h, actual %h", want.handle, handle);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic        opcode;
  logic [31:0] size_bytes;
  logic [31:0] buffer_handle;
  logic [31:0] fresh_handle;
  logic        backing_ok;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [31:0] result_handle;
  logic [2:0]  outcome;

  recycler_tracker board;
  // Set for the closing stretch of the run, where neither side idles.
  bit          calm = 1'b0;
  // A small set of sizes so that allocations often hit recycled entries.
  logic [31:0] size_pool[12];
  // Handles that have been handed out, to build frees and duplicate handles.
  logic [31:0] issued_handles[$];

  exact_size_buffer_recycler_unit #(
    .TABLE_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .opcode       (opcode),
    .size_bytes   (size_bytes),
    .buffer_handle(buffer_handle),
    .fresh_handle (fresh_handle),
    .backing_ok   (backing_ok),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_handle(result_handle),
    .outcome      (outcome)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Every response transfer is checked against the oldest pending result.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall && board != null) begin
      board.match_result(result_handle, outcome);
    end
  end

  // Response side: random stretches of stall and no stall, with some long
  // stretches of no stall. During the calm stretch the stall stays low.
  initial begin
    int unsigned stretch;
    rsp_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (calm) begin
        rsp_stall <= 1'b0;
        stretch = 1;
      end else begin
        case ($urandom_range(0, 3))
          0, 1: begin
            rsp_stall <= 1'b1;
            stretch = $urandom_range(1, 16);
          end
          2: begin
            rsp_stall <= 1'b0;
            stretch = $urandom_range(1, 16);
          end
          default: begin
            rsp_stall <= 1'b0;
            stretch = $urandom_range(20, 60);
          end
        endcase
      end
      repeat (stretch) @(negedge clk);
    end
  end

  // Drives one request from a falling edge, holds it until the transfer, and
  // returns at the next falling edge with req_valid still high.
  task automatic send_req(recycle_req_t r);
    req_valid     <= 1'b1;
    opcode        <= r.op;
    size_bytes    <= r.size;
    buffer_handle <= r.handle;
    fresh_handle  <= r.fresh;
    backing_ok    <= r.ok;
    do @(posedge clk); while (req_stall);
    board.take_request(r);
    if (r.op == OP_ALLOC && r.ok) issued_handles.push_back(r.fresh);
    @(negedge clk);
  endtask

  task automatic idle_sender(int unsigned cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Holds the request side off until every pending result has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Unused fields carry random values so that the block must ignore them.
  function automatic recycle_req_t alloc_req(logic [31:0] size, logic [31:0] fresh,
                                             logic ok);
    recycle_req_t r;
    r.op     = OP_ALLOC;
    r.size   = size;
    r.handle = $urandom;
    r.fresh  = fresh;
    r.ok     = ok;
    return r;
  endfunction

  function automatic recycle_req_t free_req(logic [31:0] handle);
    recycle_req_t r;
    r.op     = OP_FREE;
    r.size   = $urandom;
    r.handle = handle;
    r.fresh  = $urandom;
    r.ok     = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Random traffic: sizes mostly from the pool, frees mostly of handles that
  // were handed out, some duplicate and zero handles, some failed backings.
  function automatic recycle_req_t random_request();
    logic [31:0] size;
    logic [31:0] fresh;
    logic        ok;
    int unsigned pick;
    if ($urandom_range(0, 99) < 55) begin
      size = ($urandom_range(0, 3) == 0) ? $urandom : size_pool[$urandom_range(0, 11)];
      pick = $urandom_range(0, 99);
      if (pick < 10 && issued_handles.size() != 0) begin
        fresh = issued_handles[$urandom_range(0, issued_handles.size() - 1)];
      end else if (pick < 15) begin
        fresh = '0;
      end else begin
        fresh = $urandom;
      end
      ok = ($urandom_range(0, 9) != 0);
      return alloc_req(size, fresh, ok);
    end
    if ($urandom_range(0, 9) < 7 && issued_handles.size() != 0) begin
      return free_req(issued_handles[$urandom_range(0, issued_handles.size() - 1)]);
    end
    return free_req($urandom);
  endfunction

  initial begin
    int unsigned gap_odds;
    int unsigned idx;
    board = new();
    rst           = 1'b1;
    req_valid     = 1'b0;
    opcode        = OP_ALLOC;
    size_bytes    = '0;
    buffer_handle = '0;
    fresh_handle  = '0;
    backing_ok    = 1'b0;
    size_pool[0] = 32'd0;
    size_pool[1] = 32'd1;
    size_pool[2] = 32'd64;
    size_pool[3] = 32'd4096;
    size_pool[4] = 32'hFFFF_FFFF;
    size_pool[5] = 32'h8000_0000;
    for (idx = 6; idx < 12; idx++) size_pool[idx] = $urandom;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Frees on an empty table go back to the backing allocator.
    send_req(free_req(32'h0000_0000));
    send_req(free_req(32'hFFFF_FFFF));
    // A failed backing allocation on a miss returns handle zero.
    send_req(alloc_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
    // Handle zero is tracked like any other handle.
    send_req(alloc_req(32'h0000_0000, 32'h0000_0000, 1'b1));
    send_req(alloc_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_req(alloc_req(32'h0000_0000, 32'h1234_5678, 1'b1));
    send_req(free_req(32'h0000_0000));
    // Freeing an entry that is already free leaves it free.
    send_req(free_req(32'h0000_0000));
    // A hit ignores the backing data, even a failed backing allocation.
    send_req(alloc_req(32'h0000_0000, 32'hDEAD_BEEF, 1'b0));
    send_req(free_req(32'hFFFF_FFFF));
    send_req(alloc_req(32'hFFFF_FFFF, 32'h0BAD_F00D, 1'b1));
    // The same handle in two entries: the free must mark the later one.
    send_req(alloc_req(32'd64, 32'hA5A5_A5A5, 1'b1));
    send_req(alloc_req(32'd128, 32'hA5A5_A5A5, 1'b1));
    send_req(free_req(32'hA5A5_A5A5));
    send_req(alloc_req(32'd64, 32'h5555_5555, 1'b0));
    send_req(alloc_req(32'd128, 32'h7777_7777, 1'b0));
    send_req(free_req(32'h5A5A_5A5A));
    send_req(free_req(32'h1234_5678));
    send_req(alloc_req(32'h0000_0000, 32'h0000_0001, 1'b1));
    send_req(alloc_req(32'h0000_0000, 32'h0000_0002, 1'b1));
    drain_results();

    // Random part, in phases of a hundred requests with varying idle density.
    // The table fills along the way, so later misses come back untracked.
    gap_odds = 0;
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      if (idx % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_odds = 0;
          1:       gap_odds = 8;
          default: gap_odds = 3;
        endcase
        if (idx == RANDOM_ITEMS / 2) drain_results();
      end
      if (idx == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        idle_sender($urandom_range(1, 16));
      end
      send_req(random_request());
    end
    req_valid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    // Extra cycles catch any response beyond the expected ones.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("[exact_size_buffer_recycler_unit] OK");
    end else begin
      $display("[exact_size_buffer_recycler_unit] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("[exact_size_buffer_recycler_unit] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
src/esbr_pkg.sv
src/esbr_ram.sv
src/esbr_scan.sv
src/exact_size_buffer_recycler_unit.sv
bench/tb_top.sv
